// ===== rtl/core/mi2_pkg.sv =====
package mi2_pkg;

    // Long division of a 41-bit dividend: one quotient bit per stage.
    localparam int DIV_STEPS = 41;
    localparam int NUM_W     = 41;
    localparam int DEN_W     = 33;
    localparam int LANES     = 4;

    localparam logic [NUM_W-1:0] POS_LIMIT = 41'h0007FFFFFFF;
    localparam logic [NUM_W-1:0] NEG_LIMIT = 41'h00080000000;

    // Per-lane divider state: the partial remainder, the dividend bits still to be
    // consumed with the quotient bits shifted in behind them, and the result sign.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] sh;
        logic             neg;
    } mi2_lane_t;

endpackage

// ===== rtl/core/mi2_div_step.sv =====
module mi2_div_step (
    input  mi2_pkg::mi2_lane_t         lane_in,
    input  logic [mi2_pkg::DEN_W-1:0]  den,
    output mi2_pkg::mi2_lane_t         lane_out
);
    import mi2_pkg::*;

    logic [DEN_W:0] trial;
    logic           take;

    always_comb
    begin
        trial = {lane_in.rem, lane_in.sh[NUM_W-1]};
        take  = (trial >= {1'b0, den});
        lane_out.neg = lane_in.neg;
        lane_out.sh  = {lane_in.sh[NUM_W-2:0], take};
        if (take)
        begin
            lane_out.rem = DEN_W'(trial - {1'b0, den});
        end
        else
        begin
            lane_out.rem = trial[DEN_W-1:0];
        end
    end

endmodule

// ===== rtl/core/matrix_inverse_2x2.sv =====
// Inverse of a 2x2 matrix by the adjugate method, one matrix per word.
// Input stream s_axis: tdata carries entries a, b, c, d as signed Q8.8.
// Output stream m_axis: tdata carries the four inverse entries as signed
// Q16.16, tuser carries the singular and overflow flags.
// Configuration channel cfg: one 32-bit write sets the singular threshold;
// it is always ready and should only be written while the block is idle.
// From the accepting edge to output valid a word passes one stage for the
// products, one for the determinant and dividend setup, 41 stages of a
// radix-2 divider (one quotient bit per stage, four lanes side by side) and
// an output register that applies saturation and sign.
// Throughput is one matrix per cycle while the receiver does not stall; the
// 41-stage divider pipeline sets the latency.
// Reset clears all valid bits and the threshold to zero.
// When the receiver stalls, each stage holds until the one ahead of it has
// room, so bubbles collapse and input is refused only when every stage is
// full.
module matrix_inverse_2x2 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,      // singular_threshold
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // entry_a, entry_b, entry_c, entry_d
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // inverse_a, inverse_b, inverse_c, inverse_d
    output logic [1:0]   m_axis_tuser   // singular, overflow
);
    import mi2_pkg::*;

    logic [31:0] thr_reg;

    logic               v1_reg;
    logic signed [31:0] pad_reg, pbc_reg;
    logic signed [15:0] a1_reg, b1_reg, c1_reg, d1_reg;

    logic               v2_reg;
    logic               sing2_reg;
    logic [DEN_W-1:0]   den2_reg;
    mi2_lane_t          lane2_reg [LANES];

    logic               vd_reg   [DIV_STEPS];
    logic               singd_reg[DIV_STEPS];
    logic [DEN_W-1:0]   dend_reg [DIV_STEPS];
    mi2_lane_t          laned_reg[DIV_STEPS][LANES];
    mi2_lane_t          laned_next[DIV_STEPS][LANES];

    logic               vo_reg;
    logic [127:0]       data_o_reg;
    logic [1:0]         user_o_reg;

    logic               en_o, en2, en1;
    logic               en_d[DIV_STEPS];

    logic signed [32:0] det;
    logic               det_neg;
    logic [31:0]        det_mag;
    logic [15:0]        ux[LANES];
    logic               xneg[LANES];

    logic [127:0]       data_o_next;
    logic               ovf_next;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = en1;
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = data_o_reg;
    assign m_axis_tuser  = user_o_reg;

    always_comb
    begin
        en_o = !vo_reg || m_axis_tready;
        en_d[DIV_STEPS-1] = !vd_reg[DIV_STEPS-1] || en_o;
        for (int k = DIV_STEPS-2; k >= 0; k--)
        begin
            en_d[k] = !vd_reg[k] || en_d[k+1];
        end
        en2 = !v2_reg || en_d[0];
        en1 = !v1_reg || en2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 32'd0;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Stage 1: the two products of the determinant.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            a1_reg  <= s_axis_tdata[15:0];
            b1_reg  <= s_axis_tdata[31:16];
            c1_reg  <= s_axis_tdata[47:32];
            d1_reg  <= s_axis_tdata[63:48];
            pad_reg <= $signed(s_axis_tdata[15:0])  * $signed(s_axis_tdata[63:48]);
            pbc_reg <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[47:32]);
        end
    end

    // Stage 2: determinant, singular test and the rounding dividends 2*x*2^24 + |det|.
    always_comb
    begin
        det     = 33'(pad_reg) - 33'(pbc_reg);
        det_neg = det[32];
        det_mag = det_neg ? 32'(-det) : det[31:0];
        xneg[0] = d1_reg[15];
        xneg[1] = !b1_reg[15] && (b1_reg != 16'sd0);
        xneg[2] = !c1_reg[15] && (c1_reg != 16'sd0);
        xneg[3] = a1_reg[15];
        ux[0]   = d1_reg[15] ? 16'(-d1_reg) : 16'(d1_reg);
        ux[1]   = b1_reg[15] ? 16'(-b1_reg) : 16'(b1_reg);
        ux[2]   = c1_reg[15] ? 16'(-c1_reg) : 16'(c1_reg);
        ux[3]   = a1_reg[15] ? 16'(-a1_reg) : 16'(a1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            sing2_reg <= (det_mag <= thr_reg);
            den2_reg  <= {det_mag, 1'b0};
            for (int j = 0; j < LANES; j++)
            begin
                lane2_reg[j].rem <= '0;
                lane2_reg[j].sh  <= {ux[j], 25'd0} + NUM_W'(det_mag);
                lane2_reg[j].neg <= xneg[j] != det_neg;
            end
        end
    end

    // Divider stages.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        for (genvar j = 0; j < LANES; j++)
        begin : g_lane
            if (k == 0)
            begin : g_first
                mi2_div_step u_step (
                    .lane_in  (lane2_reg[j]),
                    .den      (den2_reg),
                    .lane_out (laned_next[k][j])
                );
            end
            else
            begin : g_rest
                mi2_div_step u_step (
                    .lane_in  (laned_reg[k-1][j]),
                    .den      (dend_reg[k-1]),
                    .lane_out (laned_next[k][j])
                );
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[k] <= 1'b0;
            end
            else if (en_d[k])
            begin
                vd_reg[k] <= (k == 0) ? v2_reg : vd_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en_d[k])
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    laned_reg[k][j] <= laned_next[k][j];
                end
                dend_reg[k]  <= (k == 0) ? den2_reg : dend_reg[(k == 0) ? 0 : k-1];
                singd_reg[k] <= (k == 0) ? sing2_reg : singd_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Output stage: saturation and sign, with singular results forced to zero.
    always_comb
    begin
        logic [NUM_W-1:0] q;
        logic [NUM_W-1:0] lim;
        logic [31:0]      mag;
        data_o_next = '0;
        ovf_next    = 1'b0;
        for (int j = 0; j < LANES; j++)
        begin
            q   = laned_reg[DIV_STEPS-1][j].sh;
            lim = laned_reg[DIV_STEPS-1][j].neg ? NEG_LIMIT : POS_LIMIT;
            if (q > lim)
            begin
                mag      = lim[31:0];
                ovf_next = 1'b1;
            end
            else
            begin
                mag = q[31:0];
            end
            data_o_next[j*32 +: 32] = laned_reg[DIV_STEPS-1][j].neg ? (32'd0 - mag) : mag;
        end
        if (singd_reg[DIV_STEPS-1])
        begin
            data_o_next = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en_o)
        begin
            vo_reg <= vd_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o && vd_reg[DIV_STEPS-1])
        begin
            data_o_reg <= data_o_next;
            user_o_reg <= {ovf_next, singd_reg[DIV_STEPS-1]};
        end
    end

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused while the output side was not stalled");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted word did not reach the product stage");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
        else $error("singular result carries nonzero data or overflow");

endmodule
